### hdl/trial_division_prime_check_core_assert.svh
// assertion macros for the prime check core checker
`ifndef TRIAL_DIVISION_PRIME_CHECK_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_CHECK_CORE_ASSERT_SVH

// clocked assertion with an explicit clock and reset
`define TDPC_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked assertion on the local clk and rst
`define TDPC_ASSERT(lbl, prop, msg) \
  `TDPC_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

### hdl/tdpc_pkg.sv
// shared types and constants of the prime check core
package tdpc_pkg;

  // width of the number field on the request channel
  localparam int NUMBER_W = 32;

  typedef logic [NUMBER_W-1:0] number_t;

endpackage

### hdl/tdpc_if.sv
// request and response channel interfaces of the prime check core
interface tdpc_req_if import tdpc_pkg::*; ();
  logic    valid;
  logic    ready;
  number_t number_value;

  modport source (output valid, output number_value, input ready);
  modport sink   (input valid, input number_value, output ready);
endinterface

interface tdpc_rsp_if ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

### hdl/trial_division_prime_check_core.sv
// Trial division prime check core.
// The req channel carries one number per request; the rsp channel returns
// one is_prime bit per request, in order. A request is taken when
// req.valid and req.ready are high at a rising edge of clk.
// The test masks the number to VALUE_WIDTH bits (at most the field width),
// answers values below nine and even values at once, and otherwise tries every
// odd divisor d from 3 while d*d does not exceed the number.
// Each divisor runs through one shared restoring remainder unit, one
// quotient bit per cycle.
// req.ready is high only while no test is running; one request is worked
// at a time. The answer sits in an output register, so a new request is
// taken while an earlier answer still waits on rsp.ready; a finished test
// holds its answer until that register is free.
// rst (synchronous, active high) drops any test in progress and clears
// the pending response.
module trial_division_prime_check_core import tdpc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  tdpc_req_if.sink       req,
  tdpc_rsp_if.source     rsp
);

  // effective width: the field width bounds the tested value
  localparam int VW    = (VALUE_WIDTH < NUMBER_W) ? VALUE_WIDTH : NUMBER_W;
  localparam int SQ_W  = VW + 2;
  localparam int BIT_W = (VW > 1) ? $clog2(VW) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_NEXT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]      state;
  logic [VW-1:0]   n;
  logic [VW-1:0]   d;
  logic [SQ_W-1:0] sq;
  logic [VW-1:0]   rem;
  logic [BIT_W-1:0] bitcnt;
  logic            res_bit;
  logic            out_valid;
  logic            out_prime;

  logic [VW:0]     rem_sh;
  logic [VW:0]     rem_sub;
  logic            rem_ge;
  logic [VW-1:0]   rem_next;
  logic [SQ_W-1:0] sq_next;
  logic            out_free;

  // shared remainder step: shift in one bit of n, subtract d if it fits
  always_comb begin
    rem_sh   = {rem, n[bitcnt]};
    rem_sub  = rem_sh - {1'b0, d};
    rem_ge   = !rem_sub[VW];
    rem_next = rem_ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
  end

  // square of the next odd divisor: (d+2)^2 = d^2 + 4d + 4
  assign sq_next  = sq + {d, 2'b00} + SQ_W'(4);
  assign out_free = !out_valid || rsp.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            n     <= req.number_value[VW-1:0];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          d      <= VW'(3);
          sq     <= SQ_W'(9);
          rem    <= '0;
          bitcnt <= BIT_W'(VW - 1);
          if (n[VW-1:1] == '0) begin
            res_bit <= 1'b0;
            state   <= ST_FINISH;
          end else if ((n >> 2) == '0) begin
            res_bit <= 1'b1;
            state   <= ST_FINISH;
          end else if (!n[0]) begin
            res_bit <= 1'b0;
            state   <= ST_FINISH;
          end else if (SQ_W'(9) > {2'b00, n}) begin
            res_bit <= 1'b1;
            state   <= ST_FINISH;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          if (bitcnt == '0) begin
            state <= ST_NEXT;
          end else begin
            bitcnt <= bitcnt - BIT_W'(1);
          end
        end
        ST_NEXT: begin
          if (rem == '0) begin
            res_bit <= 1'b0;
            state   <= ST_FINISH;
          end else begin
            d      <= d + VW'(2);
            sq     <= sq_next;
            rem    <= '0;
            bitcnt <= BIT_W'(VW - 1);
            if (sq_next > {2'b00, n}) begin
              res_bit <= 1'b1;
              state   <= ST_FINISH;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
      out_prime <= res_bit;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.is_prime = out_prime;

endmodule

### hdl/tdpc_checker.sv
// port level checks of the prime check core, bound to the top level
`include "trial_division_prime_check_core_assert.svh"

module tdpc_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic is_prime
);

  // one test at a time: a taken request closes the request side
  `TDPC_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "ready after request")

  // a new response only shows up while a test is running
  `TDPC_ASSERT(a_rsp_from_test, $rose(rsp_valid) |-> !$past(req_ready), "response without test")

  // a stalled response stays up
  `TDPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

  // a stalled response keeps its value
  `TDPC_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(is_prime), "response changed")

endmodule

bind trial_division_prime_check_core tdpc_checker u_tdpc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .is_prime  (rsp.is_prime)
);

### verif/tb.sv
// self-checking testbench for the trial division prime check core
`timescale 1ns / 100ps

module tb;
  import tdpc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int PRESSURE_HOLD = 400;
  localparam int PRESSURE_AT   = 6;
  localparam int IDLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_ITEMS  = 100;
  // odd divisors allowed for a full-range random value, keeps runs short
  localparam int unsigned MAX_TRIALS = 200;

  typedef struct packed {
    number_t number_value;
    logic    is_prime;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    req_valid  = 1'b0;
  number_t req_number = '0;
  logic    rsp_ready  = 1'b0;

  tdpc_req_if req_ch ();
  tdpc_rsp_if rsp_ch ();

  assign req_ch.valid        = req_valid;
  assign req_ch.number_value = req_number;
  assign rsp_ch.ready        = rsp_ready;

  trial_division_prime_check_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  number_t     number_q[$];
  verdict_t    verdict_q[$];
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  int unsigned rsp_count     = 0;
  int unsigned prime_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned fail_count    = 0;
  bit          pressure_done = 1'b0;

  // trial division over odd divisors, also reports how many were tried
  function automatic logic prime_by_division(input number_t n, output int unsigned trials);
    number_t d;
    trials = 0;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      trials++;
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin : req_driver
    int unsigned trials;
    logic        prime_bit;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else if (!req_valid || req_ch.ready) begin
      // request taken at this edge
      if (req_valid) begin
        prime_bit = prime_by_division(req_number, trials);
        verdict_q.push_back('{number_value: req_number, is_prime: prime_bit});
      end
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (number_q.size() != 0) begin
        req_valid  <= 1'b1;
        req_number <= number_q.pop_front();
        gap_left   <= draw_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk) begin : rsp_monitor
    verdict_t want;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        rsp_count <= rsp_count + 1;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected response is_prime=%0b", $time, rsp_ch.is_prime);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (rsp_ch.is_prime) prime_count <= prime_count + 1;
          if (rsp_ch.is_prime !== want.is_prime) begin
            $display("%0t: number %0d expected is_prime=%0b actual=%0b", $time,
                     want.number_value, want.is_prime, rsp_ch.is_prime);
            fail_count++;
          end
        end
      end
      // long hold-off once so the core fills up and stalls requests
      if (!pressure_done && rsp_count == PRESSURE_AT) begin
        pressure_done <= 1'b1;
        stall_left    <= PRESSURE_HOLD;
        rsp_ready     <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        rsp_ready <= 1'b1;
      end else begin
        stall_left <= draw_gap();
        rsp_ready  <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    number_t     n;
    number_t     largest;
    int unsigned trials;
    int unsigned sel;
    int unsigned p;
    int unsigned total;
    logic        prime_bit;

    // zero, one, two, small primes and squares, field extremes
    number_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
                 32'd49, 32'd91, 32'd97, 32'd121, 32'd65536, 32'd65537, 32'd1042441,
                 32'd1048573, 32'd1052651, 32'h8000_0000, 32'h8000_0001,
                 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

    // random part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        n = $urandom_range(0, 4095);
      end else if (sel < 60) begin
        n = $urandom_range(0, 1 << 20);
      end else if (sel < 72) begin
        // products of close odd values hit the d*d == n boundary
        p = $urandom_range(1, 511) * 2 + 1;
        n = $urandom_range(0, 1) ? p * p : p * (p + 2);
      end else begin
        do begin
          n = $urandom();
          prime_bit = prime_by_division(n, trials);
        end while (trials > MAX_TRIALS);
      end
      number_q.push_back(n);
    end

    total   = number_q.size();
    largest = '0;
    foreach (number_q[i]) if (number_q[i] > largest) largest = number_q[i];

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to come back
    while (rsp_count < total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d answered prime, largest value %0d", total,
             prime_count, largest);
    $display("response side held off %0d cycles once while requests kept coming",
             PRESSURE_HOLD);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
